@@ design/huffman_bit_packer_unit_defines.svh @@
// assertion macros shared by the huffman bit packer rtl
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define HBP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger in one cycle implies a condition in the next cycle
`define HBP_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/hbp_pkg.sv @@
// shared types and constants for the huffman bit packer
// no dependencies
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 24;
  localparam int LEN_W     = 5;
  localparam int IN_DATA_W = 40;
  localparam int BYTE_W    = 8;
  localparam int VBITS_W   = 4;
  localparam int WORD_W    = 32;

  // input kind carried in tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // one table entry
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } entry_t;

  // request from the packer to the code table
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } tbl_req_t;

endpackage

@@ design/hbp_table.sv @@
// code table: synchronous memory of code words and lengths with per-entry valid bits
// depends on hbp_pkg
`timescale 1ns / 1ps

module hbp_table #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hbp_pkg::tbl_req_t req,
  output hbp_pkg::entry_t   rd_entry
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  hbp_pkg::entry_t          mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]  valid_r;
  hbp_pkg::entry_t          rd_data_r;
  logic                     rd_ok_r;

  logic [IDX_W-1:0]            idx;
  logic                        in_range;
  logic [hbp_pkg::LEN_W-1:0]   len_sat;
  logic [hbp_pkg::WORD_W-1:0]  len_mask;
  hbp_pkg::entry_t             wr_entry;

  // index decode and range check
  assign idx      = req.symbol[IDX_W-1:0];
  assign in_range = ({1'b0, req.symbol} < 9'(SYMBOL_COUNT));

  // saturate the length and drop code bits above it
  always_comb begin
    len_sat = (req.length > hbp_pkg::LEN_W'(MAX_CODE_LENGTH)) ?
              hbp_pkg::LEN_W'(MAX_CODE_LENGTH) : req.length;
    len_mask = ~({hbp_pkg::WORD_W{1'b1}} << len_sat);
    wr_entry.length = len_sat;
    wr_entry.code   = req.code & len_mask[hbp_pkg::CODE_W-1:0];
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      mem[idx] <= wr_entry;
    end
    if (req.rd) begin
      rd_data_r <= mem[idx];
    end
  end

  // valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (req.wr && in_range) begin
        valid_r[idx] <= 1'b1;
      end
      if (req.rd) begin
        rd_ok_r <= in_range && valid_r[idx];
      end
    end
  end

  assign rd_entry = rd_ok_r ? rd_data_r : '0;

endmodule

@@ design/huffman_bit_packer_unit.sv @@
// huffman bit packer top level: code table lookup, bit accumulator and byte emitter
// depends on hbp_pkg, hbp_table and huffman_bit_packer_unit_defines.svh
// an encode word goes to the lookup stage, then its bytes go to the emit stage
// throughput: one word per cycle while out_tready is high and each encode yields
//   at most one byte; a word of n bytes (up to 4) holds the emit stage until sent
// reset: synchronous active-low; clears the accumulator, pipeline and table valid bits
`timescale 1ns / 1ps
`include "huffman_bit_packer_unit_defines.svh"

module huffman_bit_packer_unit #(
  parameter int SYMBOL_COUNT    = 256,
  parameter int MAX_CODE_LENGTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // symbol [7:0], code_bits [31:8], code_length [36:32], zero [39:37]
  input  logic [hbp_pkg::IN_DATA_W-1:0]  in_tdata,
  // op [0]
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_byte [7:0]
  output logic [hbp_pkg::BYTE_W-1:0]     out_tdata,
  // valid_bits [3:0]
  output logic [hbp_pkg::VBITS_W-1:0]    out_tuser,
  output logic                           out_tlast
);

  localparam int W = hbp_pkg::WORD_W;

  hbp_pkg::tbl_req_t tbl_req;
  hbp_pkg::entry_t   tbl_entry;

  logic in_fire;
  logic out_fire;

  // lookup stage
  logic s1_valid_r, s1_valid_nxt;
  logic s1_last_r,  s1_last_nxt;

  // accumulator
  logic [6:0] acc_r,  acc_nxt;
  logic [2:0] pend_r, pend_nxt;

  // byte emit stage
  logic [2:0]   s2_cnt_r,  s2_cnt_nxt;
  logic [W-1:0] s2_word_r, s2_word_nxt;
  logic         s2_last_r, s2_last_nxt;
  logic         s2_pad_r,  s2_pad_nxt;
  logic [2:0]   s2_rem_r,  s2_rem_nxt;

  logic [W-1:0] combined;
  logic [W-1:0] aligned;
  logic [5:0]   nbits;
  logic [5:0]   align_sh;
  logic [2:0]   rem;
  logic         pad;
  logic [2:0]   res_cnt;
  logic [6:0]   rem_mask;
  logic         s2_free;
  logic         s1_adv;
  logic         out_final;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // table access at accept time
  always_comb begin
    tbl_req.wr     = in_fire && (in_tuser == hbp_pkg::OP_LOAD);
    tbl_req.rd     = in_fire && (in_tuser == hbp_pkg::OP_ENCODE);
    tbl_req.symbol = in_tdata[7:0];
    tbl_req.code   = in_tdata[31:8];
    tbl_req.length = in_tdata[36:32];
  end

  hbp_table #(
    .SYMBOL_COUNT    (SYMBOL_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_entry (tbl_entry)
  );

  // append the code to the pending bits and left-align the result
  always_comb begin
    nbits    = 6'(pend_r) + 6'(tbl_entry.length);
    combined = (W'(acc_r) << tbl_entry.length) | W'(tbl_entry.code);
    align_sh = 6'd32 - nbits;
    aligned  = combined << align_sh;
    rem      = nbits[2:0];
    pad      = s1_last_r && (rem != 3'd0);
    res_cnt  = nbits[5:3] + 3'(pad);
    rem_mask = ~(7'h7F << rem);
  end

  // handshake between stages
  assign s2_free   = (s2_cnt_r == 3'd0) || ((s2_cnt_r == 3'd1) && out_tready);
  assign s1_adv    = s1_valid_r && ((res_cnt == 3'd0) || s2_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // lookup stage and accumulator next state
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_last_nxt  = s1_last_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      if (s1_last_r) begin
        acc_nxt  = '0;
        pend_nxt = '0;
      end else begin
        acc_nxt  = combined[6:0] & rem_mask;
        pend_nxt = rem;
      end
    end
    if (tbl_req.rd) begin
      s1_valid_nxt = 1'b1;
      s1_last_nxt  = in_tlast;
    end
  end

  // emit stage next state
  always_comb begin
    s2_cnt_nxt  = s2_cnt_r;
    s2_word_nxt = s2_word_r;
    s2_last_nxt = s2_last_r;
    s2_pad_nxt  = s2_pad_r;
    s2_rem_nxt  = s2_rem_r;
    if (s1_adv && (res_cnt != 3'd0)) begin
      s2_cnt_nxt  = res_cnt;
      s2_word_nxt = aligned;
      s2_last_nxt = s1_last_r;
      s2_pad_nxt  = pad;
      s2_rem_nxt  = rem;
    end else if (out_fire) begin
      s2_cnt_nxt  = s2_cnt_r - 3'd1;
      s2_word_nxt = s2_word_r << 8;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      pend_r     <= '0;
      s2_cnt_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
      pend_r     <= pend_nxt;
      s2_cnt_r   <= s2_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_last_r <= s1_last_nxt;
    s2_word_r <= s2_word_nxt;
    s2_last_r <= s2_last_nxt;
    s2_pad_r  <= s2_pad_nxt;
    s2_rem_r  <= s2_rem_nxt;
  end

  // output byte, top of the emit word
  assign out_final  = (s2_cnt_r == 3'd1);
  assign out_tvalid = (s2_cnt_r != 3'd0);
  assign out_tdata  = s2_word_r[W-1:W-8];
  assign out_tlast  = out_final && s2_last_r;
  assign out_tuser  = (out_final && s2_pad_r) ? {1'b0, s2_rem_r} : 4'd8;

  // checks
  `HBP_ASSERT_ALWAYS(a_cnt_range, (s2_cnt_r <= 3'd4), "emit count above four")
  `HBP_ASSERT_ALWAYS(a_acc_clean, ((acc_r & (7'h7F << pend_r)) == 7'd0),
    "accumulator holds bits above the pending count")
  `HBP_ASSERT_NEXT(a_last_clears, (s1_adv && s1_last_r), (pend_r == 3'd0 && acc_r == 7'd0),
    "accumulator not cleared after last symbol")
  `HBP_ASSERT_NEXT(a_more_bytes, (out_fire && !out_final), out_tvalid,
    "emit stage dropped remaining bytes")

endmodule
